@@ rtl/jdcm_pkg.sv @@
// ----------------------------------------------------------------------------
// jdcm_pkg: shared types and codes of the joystick drive command mixer
// Message, result, configuration and state records, button letters,
// buzzer tones and configuration register indexes.
// ----------------------------------------------------------------------------
package jdcm_pkg;

  // Field widths of the remote message and the result.
  localparam int unsigned JOY_W   = 8;
  localparam int unsigned BTN_W   = 8;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned AXIS_W  = 11;   // scaled axis, -1000..1000
  localparam int unsigned MAG_W   = 10;   // magnitude of a scaled axis
  localparam int unsigned DB_W    = 7;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned TONE_W  = 10;

  // Stream and configuration port widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Message kinds carried in in_tuser.
  localparam logic CMD_JOYSTICK = 1'b0;
  localparam logic CMD_BUTTON   = 1'b1;

  // Drive mode codes.
  localparam logic MODE_NONE  = 1'b0;
  localparam logic MODE_SPEED = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_DEADBAND      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIAG_THRESH   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_THRESH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STRAIGHT_SPD  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TURN_SPD      = 3'd4;

  // Configuration reset values.
  localparam logic [DB_W-1:0]  DEADBAND_RST      = 7'd5;
  localparam logic [THR_W-1:0] DIAG_THRESH_RST   = 10'd200;
  localparam logic [THR_W-1:0] SINGLE_THRESH_RST = 10'd100;
  localparam logic [THR_W-1:0] STRAIGHT_SPD_RST  = 10'd700;
  localparam logic [THR_W-1:0] TURN_SPD_RST      = 10'd500;

  // Button letters: lower case is a short press, upper case a long press.
  localparam logic [BTN_W-1:0] BTN_U  = 8'h75;  // 'u'
  localparam logic [BTN_W-1:0] BTN_A  = 8'h61;  // 'a'
  localparam logic [BTN_W-1:0] BTN_W_ = 8'h77;  // 'w'
  localparam logic [BTN_W-1:0] BTN_C  = 8'h63;  // 'c'
  localparam logic [BTN_W-1:0] BTN_L  = 8'h6C;  // 'l'
  localparam logic [BTN_W-1:0] BTN_D  = 8'h64;  // 'd'
  localparam logic [BTN_W-1:0] BTN_R  = 8'h72;  // 'r'
  localparam logic [BTN_W-1:0] BTN_B  = 8'h62;  // 'b'
  localparam logic [BTN_W-1:0] BTN_S  = 8'h73;  // 's'
  localparam logic [BTN_W-1:0] BTN_G  = 8'h67;  // 'g'
  localparam logic [BTN_W-1:0] BTN_LA = 8'h41;  // 'A'
  localparam logic [BTN_W-1:0] BTN_LB = 8'h42;  // 'B'
  localparam logic [BTN_W-1:0] BTN_LC = 8'h43;  // 'C'
  localparam logic [BTN_W-1:0] BTN_LD = 8'h44;  // 'D'
  localparam logic [BTN_W-1:0] BTN_E  = 8'h65;  // 'e'
  localparam logic [BTN_W-1:0] BTN_LE = 8'h45;  // 'E'
  localparam logic [BTN_W-1:0] BTN_F  = 8'h66;  // 'f'
  localparam logic [BTN_W-1:0] BTN_LF = 8'h46;  // 'F'
  localparam logic [BTN_W-1:0] BTN_LG = 8'h47;  // 'G'

  // Buzzer tones.
  localparam logic [TONE_W-1:0] FREQ_LOW   = 10'd300;
  localparam logic [TONE_W-1:0] FREQ_HIGH  = 10'd500;
  localparam logic [TONE_W-1:0] MS_50      = 10'd50;
  localparam logic [TONE_W-1:0] MS_200     = 10'd200;
  localparam logic [TONE_W-1:0] MS_500     = 10'd500;
  localparam logic [TONE_W-1:0] MS_800     = 10'd800;
  localparam logic [TONE_W-1:0] MS_1000    = 10'd1000;

  // Axis scaling constants.
  localparam logic [MAG_W-1:0] SCALE_STEP = 10'd100;
  localparam int unsigned      POS_DIV    = 127;
  localparam int unsigned      NEG_SHIFT  = 7;     // divide by 128
  localparam int unsigned      MAX_QUOT   = 10;

  typedef struct packed {
    logic                    command;
    logic                    drive_allowed;
    logic [BTN_W-1:0]        button_code;
    logic signed [JOY_W-1:0] joy_y;
    logic signed [JOY_W-1:0] joy_x;
  } jdcm_in_t;

  // Declared from the highest tdata bit down, so it packs straight onto tdata.
  typedef struct packed {
    logic                      joystick_on_now;
    logic                      remote_on_now;
    logic                      toggle_hand_rule;
    logic                      toggle_follow;
    logic [TONE_W-1:0]         buzz_ms;
    logic [TONE_W-1:0]         buzz_freq;
    logic                      buzz_valid;
    logic                      mode_code;
    logic                      mode_valid;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic                      drive_valid;
  } jdcm_result_t;

  typedef struct packed {
    logic [DB_W-1:0]  deadband;
    logic [THR_W-1:0] diagonal_threshold;
    logic [THR_W-1:0] single_axis_threshold;
    logic [THR_W-1:0] button_straight_speed;
    logic [THR_W-1:0] button_turn_speed;
  } jdcm_cfg_t;

  typedef struct packed {
    logic remote_enabled;
    logic joystick_enabled;
  } jdcm_state_t;

endpackage

@@ rtl/jdcm_scale.sv @@
// ----------------------------------------------------------------------------
// jdcm_scale: joystick axis deadband and scaling
// Forces small magnitudes to zero and scales the axis to -1000..1000 in
// steps of 100, truncating toward zero.
// ----------------------------------------------------------------------------
module jdcm_scale (
  input  logic signed [jdcm_pkg::JOY_W-1:0]  axis_in,
  input  logic [jdcm_pkg::DB_W-1:0]          deadband,
  output logic signed [jdcm_pkg::AXIS_W-1:0] axis_out
);
  import jdcm_pkg::*;

  logic [JOY_W-1:0]  mag;
  logic              in_band;
  logic              is_pos;
  logic              is_neg;
  logic [10:0]       prod;
  logic [3:0]        quot;
  logic [MAG_W-1:0]  scaled;

  always_comb begin
    // Magnitude of -128 is 128, which still fits as unsigned.
    mag     = axis_in[JOY_W-1] ? JOY_W'(-axis_in) : JOY_W'(axis_in);
    in_band = mag < {1'b0, deadband};
    is_pos  = !axis_in[JOY_W-1] && (mag != '0) && !in_band;
    is_neg  = axis_in[JOY_W-1] && !in_band;
    prod    = 11'(mag) * 11'd10;
    quot    = '0;
    if (is_pos) begin
      // Quotient by 127 as a count of independent compares.
      for (int k = 1; k <= MAX_QUOT; k++) begin
        if (prod >= 11'(POS_DIV * k)) quot = 4'(k);
      end
    end else if (is_neg) begin
      quot = 4'(prod >> NEG_SHIFT);
    end
    scaled   = MAG_W'(10'(quot) * SCALE_STEP);
    axis_out = is_neg ? -AXIS_W'(scaled) : AXIS_W'(scaled);
  end

endmodule

@@ rtl/jdcm_decode.sv @@
// ----------------------------------------------------------------------------
// jdcm_decode: message decode and wheel speed mixing
// Turns one remote message into its result and the next remote and
// joystick enable state.
// ----------------------------------------------------------------------------
module jdcm_decode (
  input  jdcm_pkg::jdcm_in_t     item,
  input  jdcm_pkg::jdcm_cfg_t    cfg,
  input  jdcm_pkg::jdcm_state_t  state,
  output jdcm_pkg::jdcm_result_t res,
  output jdcm_pkg::jdcm_state_t  state_nxt
);
  import jdcm_pkg::*;

  logic signed [AXIS_W-1:0]  dir_scaled;
  logic signed [AXIS_W-1:0]  spd_scaled;
  logic signed [SPEED_W-1:0] d;
  logic signed [SPEED_W-1:0] s;
  logic [MAG_W-1:0]          mag_d;
  logic [MAG_W-1:0]          mag_s;
  logic signed [SPEED_W-1:0] st;
  logic signed [SPEED_W-1:0] tu;
  logic                      joy_live;

  jdcm_scale u_scale_x (
    .axis_in  (item.joy_x),
    .deadband (cfg.deadband),
    .axis_out (dir_scaled)
  );

  jdcm_scale u_scale_y (
    .axis_in  (item.joy_y),
    .deadband (cfg.deadband),
    .axis_out (spd_scaled)
  );

  always_comb begin
    d     = SPEED_W'(dir_scaled);
    s     = SPEED_W'(spd_scaled);
    mag_d = MAG_W'(d[SPEED_W-1] ? -d : d);
    mag_s = MAG_W'(s[SPEED_W-1] ? -s : s);
    st    = signed'({2'b00, cfg.button_straight_speed});
    tu    = signed'({2'b00, cfg.button_turn_speed});
    joy_live = state.remote_enabled && state.joystick_enabled && item.drive_allowed;

    res       = '0;
    state_nxt = state;

    if (item.command == CMD_JOYSTICK) begin
      if (joy_live) begin
        res.drive_valid = 1'b1;
        if (mag_d > cfg.diagonal_threshold && mag_s > cfg.diagonal_threshold) begin
          // Diagonal: one wheel keeps the speed axis and the other gains the turn amount in magnitude.
          if (d < 0) begin
            res.speed_left  = s;
            res.speed_right = (s < 0) ? s + d : s - d;
          end else begin
            res.speed_right = s;
            res.speed_left  = (s < 0) ? s - d : s + d;
          end
        end else if (mag_s > cfg.single_axis_threshold) begin
          res.speed_left  = s;
          res.speed_right = s;
        end else if (mag_d > cfg.single_axis_threshold) begin
          res.speed_left  = d;
          res.speed_right = -d;
        end
      end
    end else begin
      case (item.button_code) inside
        BTN_U, BTN_A: begin
          if (item.drive_allowed) begin
            res.drive_valid = 1'b1;
            res.speed_left  = st;
            res.speed_right = st;
          end
        end
        BTN_W_, BTN_C: begin
          if (item.drive_allowed) begin
            res.drive_valid = 1'b1;
            res.speed_left  = -st;
            res.speed_right = -st;
          end
        end
        BTN_L, BTN_D: begin
          if (item.drive_allowed) begin
            res.drive_valid = 1'b1;
            res.speed_left  = -tu;
            res.speed_right = tu;
          end
        end
        BTN_R, BTN_B: begin
          if (item.drive_allowed) begin
            res.drive_valid = 1'b1;
            res.speed_left  = tu;
            res.speed_right = -tu;
          end
        end
        BTN_S, BTN_G: begin
          res.drive_valid = item.drive_allowed;
        end
        BTN_LA, BTN_LB, BTN_LC, BTN_LD: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_LOW;
          res.buzz_ms    = MS_500;
        end
        BTN_E: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_LOW;
          res.buzz_ms    = MS_200;
          res.drive_valid = 1'b1;
          state_nxt.remote_enabled = 1'b1;
        end
        BTN_LE: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_HIGH;
          res.buzz_ms    = MS_800;
          res.drive_valid = 1'b1;
          res.mode_valid  = 1'b1;
          res.mode_code   = MODE_NONE;
          state_nxt.remote_enabled = 1'b0;
        end
        BTN_F: begin
          res.toggle_follow = 1'b1;
        end
        BTN_LF: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_LOW;
          res.buzz_ms    = MS_500;
          res.toggle_hand_rule = 1'b1;
        end
        BTN_LG: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_LOW;
          if (state.joystick_enabled) begin
            res.buzz_ms = MS_1000;
            state_nxt.joystick_enabled = 1'b0;
          end else begin
            res.buzz_ms     = MS_500;
            res.drive_valid = 1'b1;
            res.mode_valid  = 1'b1;
            res.mode_code   = MODE_SPEED;
            state_nxt.joystick_enabled = 1'b1;
          end
        end
        default: begin
          res.buzz_valid = 1'b1;
          res.buzz_freq  = FREQ_HIGH;
          res.buzz_ms    = MS_50;
        end
      endcase
    end

    res.remote_on_now   = state_nxt.remote_enabled;
    res.joystick_on_now = state_nxt.joystick_enabled;
  end

endmodule

@@ rtl/joystick_drive_command_mixer_core.sv @@
// ----------------------------------------------------------------------------
// joystick_drive_command_mixer_core: remote message to wheel speed mixer
// Each message, a joystick sample or a button code, yields one result
// holding wheel speeds, mode, buzzer and toggle requests. A message is held
// in an input register, decoded combinationally and captured in a result
// register, so a new message can be taken every cycle while the output does
// not stall. The combinational decode between the two registers also
// updates the remote and joystick enable flags that the next message sees.
// Configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module joystick_drive_command_mixer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // joy_x[7:0], joy_y[15:8], button_code[23:16], drive_allowed[24], zeros
  input  logic [jdcm_pkg::IN_DATA_W-1:0]      in_tdata,
  // command[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_valid[0], speed_left[12:1], speed_right[24:13], mode_valid[25],
  // mode_code[26], buzz_valid[27], buzz_freq[37:28], buzz_ms[47:38],
  // toggle_follow[48], toggle_hand_rule[49], remote_on_now[50],
  // joystick_on_now[51], zeros
  output logic [jdcm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [jdcm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [jdcm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import jdcm_pkg::*;

  jdcm_cfg_t    cfg_r;
  jdcm_state_t  state_r;
  jdcm_state_t  state_nxt;
  jdcm_in_t     in_r;
  logic         in_valid_r;
  jdcm_result_t res_nxt;
  jdcm_result_t out_r;
  logic         out_valid_r;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband              <= DEADBAND_RST;
      cfg_r.diagonal_threshold    <= DIAG_THRESH_RST;
      cfg_r.single_axis_threshold <= SINGLE_THRESH_RST;
      cfg_r.button_straight_speed <= STRAIGHT_SPD_RST;
      cfg_r.button_turn_speed     <= TURN_SPD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEADBAND:      cfg_r.deadband              <= cfg_wdata[DB_W-1:0];
        CFG_DIAG_THRESH:   cfg_r.diagonal_threshold    <= cfg_wdata[THR_W-1:0];
        CFG_SINGLE_THRESH: cfg_r.single_axis_threshold <= cfg_wdata[THR_W-1:0];
        CFG_STRAIGHT_SPD:  cfg_r.button_straight_speed <= cfg_wdata[THR_W-1:0];
        CFG_TURN_SPD:      cfg_r.button_turn_speed     <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.command       <= in_tuser;
      in_r.drive_allowed <= in_tdata[24];
      in_r.button_code   <= in_tdata[23:16];
      in_r.joy_y         <= in_tdata[15:8];
      in_r.joy_x         <= in_tdata[7:0];
    end
  end

  jdcm_decode u_decode (
    .item      (in_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .res       (res_nxt),
    .state_nxt (state_nxt)
  );

  // Enable flags move with the message that changes them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.remote_enabled   <= 1'b1;
      state_r.joystick_enabled <= 1'b1;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

  // The enable flags always match what the held result reports.
  a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.remote_on_now == state_r.remote_enabled &&
                     out_r.joystick_on_now == state_r.joystick_enabled))
    else $error("enable flags differ from the held result");

  // Setting mode none only happens on remote off, which also stops the wheels.
  a_mode_none_remote_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mode_valid && out_r.mode_code == MODE_NONE) |->
      (!out_r.remote_on_now && out_r.drive_valid && out_r.speed_left == '0 &&
       out_r.speed_right == '0))
    else $error("mode none without remote off");

  // A held message is never dropped while the result side stalls.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("input message lost");

  // No tone values without a tone request.
  a_buzz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.buzz_valid) |-> (out_r.buzz_freq == '0 && out_r.buzz_ms == '0))
    else $error("tone values without a request");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the joystick drive command mixer core
// Sends directed and random remote messages through the input stream under
// random source gaps and sink stalls. A scoreboard predicts each result from
// its own copy of the configuration and the enable flags. Every result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import jdcm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 275;
  localparam int PRINT_LIMIT = 40;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED = CFG_TURN_SPD + 3'd1;
  localparam logic [BTN_W-1:0] BTN_CODE_LOW  = 8'h00;
  localparam logic [BTN_W-1:0] BTN_CODE_HIGH = 8'hFF;
  localparam int NUM_LETTERS = 19;
  localparam logic [NUM_LETTERS*BTN_W-1:0] LETTERS = {
    BTN_U, BTN_A, BTN_W_, BTN_C, BTN_L, BTN_D, BTN_R, BTN_B, BTN_S, BTN_G,
    BTN_LA, BTN_LB, BTN_LC, BTN_LD, BTN_E, BTN_LE, BTN_F, BTN_LF, BTN_LG
  };

  class mixer_scoreboard;
    jdcm_cfg_t    cfg;
    jdcm_state_t  enables;
    jdcm_result_t expected_q[$];
    int           errors;
    int           results_seen;

    function new();
      cfg.deadband              = DEADBAND_RST;
      cfg.diagonal_threshold    = DIAG_THRESH_RST;
      cfg.single_axis_threshold = SINGLE_THRESH_RST;
      cfg.button_straight_speed = STRAIGHT_SPD_RST;
      cfg.button_turn_speed     = TURN_SPD_RST;
      enables.remote_enabled    = 1'b1;
      enables.joystick_enabled  = 1'b1;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_DEADBAND:      cfg.deadband = data[DB_W-1:0];
        CFG_DIAG_THRESH:   cfg.diagonal_threshold = data;
        CFG_SINGLE_THRESH: cfg.single_axis_threshold = data;
        CFG_STRAIGHT_SPD:  cfg.button_straight_speed = data;
        CFG_TURN_SPD:      cfg.button_turn_speed = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [SPEED_W-1:0] speed(int v);
      return v[SPEED_W-1:0];
    endfunction

    // Deadband, then quantize to tenths of full scale with truncating division.
    function int scaled_axis(logic signed [JOY_W-1:0] raw);
      int v;
      int t;
      v = raw;
      if (magnitude(v) < int'(cfg.deadband)) v = 0;
      if (v > 0) t = ((v * 10) / 127) * 100;
      else t = ((v * 10) / 128) * 100;
      if (t < -1000) t = -1000;
      else if (t > 1000) t = 1000;
      return t;
    endfunction

    function jdcm_result_t mix_message(logic cmd, logic signed [JOY_W-1:0] jx,
                                       logic signed [JOY_W-1:0] jy,
                                       logic [BTN_W-1:0] code, logic allowed);
      jdcm_result_t r;
      int d;
      int s;
      int dg;
      int sg;
      int st;
      int tu;
      r  = '0;
      st = int'(cfg.button_straight_speed);
      tu = int'(cfg.button_turn_speed);
      if (cmd == CMD_JOYSTICK) begin
        d  = scaled_axis(jx);
        s  = scaled_axis(jy);
        dg = int'(cfg.diagonal_threshold);
        sg = int'(cfg.single_axis_threshold);
        if (enables.remote_enabled && enables.joystick_enabled && allowed) begin
          r.drive_valid = 1'b1;
          if (magnitude(d) > dg && magnitude(s) > dg) begin
            if (d < 0) begin
              r.speed_left  = speed(s);
              r.speed_right = speed((s < 0) ? s + d : s - d);
            end else begin
              r.speed_right = speed(s);
              r.speed_left  = speed((s < 0) ? s - d : s + d);
            end
          end else if (magnitude(s) > sg) begin
            r.speed_left  = speed(s);
            r.speed_right = speed(s);
          end else if (magnitude(d) > sg) begin
            r.speed_left  = speed(d);
            r.speed_right = speed(-d);
          end
        end
      end else begin
        case (code)
          BTN_U, BTN_A: if (allowed) begin
            r.drive_valid = 1'b1;
            r.speed_left  = speed(st);
            r.speed_right = speed(st);
          end
          BTN_W_, BTN_C: if (allowed) begin
            r.drive_valid = 1'b1;
            r.speed_left  = speed(-st);
            r.speed_right = speed(-st);
          end
          BTN_L, BTN_D: if (allowed) begin
            r.drive_valid = 1'b1;
            r.speed_left  = speed(-tu);
            r.speed_right = speed(tu);
          end
          BTN_R, BTN_B: if (allowed) begin
            r.drive_valid = 1'b1;
            r.speed_left  = speed(tu);
            r.speed_right = speed(-tu);
          end
          BTN_S, BTN_G: r.drive_valid = allowed;
          BTN_LA, BTN_LB, BTN_LC, BTN_LD: begin
            r.buzz_valid = 1'b1;
            r.buzz_freq  = FREQ_LOW;
            r.buzz_ms    = MS_500;
          end
          BTN_E: begin
            r.buzz_valid  = 1'b1;
            r.buzz_freq   = FREQ_LOW;
            r.buzz_ms     = MS_200;
            r.drive_valid = 1'b1;
            enables.remote_enabled = 1'b1;
          end
          BTN_LE: begin
            r.buzz_valid  = 1'b1;
            r.buzz_freq   = FREQ_HIGH;
            r.buzz_ms     = MS_800;
            r.drive_valid = 1'b1;
            r.mode_valid  = 1'b1;
            r.mode_code   = MODE_NONE;
            enables.remote_enabled = 1'b0;
          end
          BTN_F: r.toggle_follow = 1'b1;
          BTN_LF: begin
            r.buzz_valid       = 1'b1;
            r.buzz_freq        = FREQ_LOW;
            r.buzz_ms          = MS_500;
            r.toggle_hand_rule = 1'b1;
          end
          BTN_LG: begin
            r.buzz_valid = 1'b1;
            r.buzz_freq  = FREQ_LOW;
            if (enables.joystick_enabled) begin
              r.buzz_ms = MS_1000;
              enables.joystick_enabled = 1'b0;
            end else begin
              r.buzz_ms     = MS_500;
              r.drive_valid = 1'b1;
              r.mode_valid  = 1'b1;
              r.mode_code   = MODE_SPEED;
              enables.joystick_enabled = 1'b1;
            end
          end
          default: begin
            r.buzz_valid = 1'b1;
            r.buzz_freq  = FREQ_HIGH;
            r.buzz_ms    = MS_50;
          end
        endcase
      end
      r.remote_on_now   = enables.remote_enabled;
      r.joystick_on_now = enables.joystick_enabled;
      return r;
    endfunction

    function void note_input(logic cmd, logic [IN_DATA_W-1:0] data);
      expected_q.push_back(mix_message(cmd, data[7:0], data[15:8], data[23:16], data[24]));
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_LIMIT) $display("ERROR: result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task compare_field(string name, logic signed [15:0] got, logic signed [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      jdcm_result_t got;
      jdcm_result_t want;
      got = data[$bits(jdcm_result_t)-1:0];
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_q.pop_front();
        compare_field("drive_valid", got.drive_valid, want.drive_valid);
        compare_field("speed_left", got.speed_left, want.speed_left);
        compare_field("speed_right", got.speed_right, want.speed_right);
        compare_field("mode_valid", got.mode_valid, want.mode_valid);
        compare_field("mode_code", got.mode_code, want.mode_code);
        compare_field("buzz_valid", got.buzz_valid, want.buzz_valid);
        compare_field("buzz_freq", got.buzz_freq, want.buzz_freq);
        compare_field("buzz_ms", got.buzz_ms, want.buzz_ms);
        compare_field("toggle_follow", got.toggle_follow, want.toggle_follow);
        compare_field("toggle_hand_rule", got.toggle_hand_rule, want.toggle_hand_rule);
        compare_field("remote_on_now", got.remote_on_now, want.remote_on_now);
        compare_field("joystick_on_now", got.joystick_on_now, want.joystick_on_now);
        compare_field("padding", data[OUT_DATA_W-1:$bits(jdcm_result_t)], 16'sd0);
      end
      results_seen++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mixer_scoreboard mixer;
  logic calm = 1'b0;
  int   cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  joystick_drive_command_mixer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // The sink stalls at random except during the calm phase.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 38);
  end

  // Results are checked before inputs are noted, so nothing hinges on process order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) mixer.check_result(out_tdata);
      if (in_tvalid && in_tready) mixer.note_input(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_msg(input logic cmd, input int jx, input int jy, input int code,
                          input logic allowed);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-25){1'b0}}, allowed, code[7:0], jy[7:0], jx[7:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One edge first, so that a transfer taken at this edge is already noted.
  task automatic wait_idle();
    do @(posedge clk); while (mixer.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    mixer.write_reg(addr, data[CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int random_axis();
    int m;
    if ($urandom_range(0, 9) < 3) begin
      m = $urandom_range(0, 12);
      return $urandom_range(0, 1) ? -m : m;
    end
    return $urandom_range(0, 255);
  endfunction

  // Scaled axes move in steps of 100, so thresholds sit on and between steps.
  function automatic int random_level();
    int lvl;
    lvl = 100 * $urandom_range(0, 10);
    if ($urandom_range(0, 1) && lvl < 1000) lvl += $urandom_range(1, 99);
    return lvl;
  endfunction

  task automatic configure(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_DEADBAND, 0);
        write_reg(CFG_DIAG_THRESH, 0);
        write_reg(CFG_SINGLE_THRESH, 0);
        write_reg(CFG_STRAIGHT_SPD, 0);
        write_reg(CFG_TURN_SPD, 0);
      end
      1: begin
        // All ten data bits set: the deadband register keeps its low seven.
        write_reg(CFG_DEADBAND, 1023);
        write_reg(CFG_DIAG_THRESH, 1000);
        write_reg(CFG_SINGLE_THRESH, 1000);
        write_reg(CFG_STRAIGHT_SPD, 1000);
        write_reg(CFG_TURN_SPD, 1000);
      end
      default: begin
        write_reg(CFG_DEADBAND, $urandom_range(0, 20));
        write_reg(CFG_DIAG_THRESH, random_level());
        write_reg(CFG_SINGLE_THRESH, random_level());
        write_reg(CFG_STRAIGHT_SPD, $urandom_range(0, 1000));
        write_reg(CFG_TURN_SPD, $urandom_range(0, 1000));
      end
    endcase
    write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom_range(0, 1023));
  endtask

  task automatic send_random();
    int   jx;
    int   jy;
    int   code;
    logic allowed;
    jx      = random_axis();
    jy      = random_axis();
    allowed = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 3) == 0) code = $urandom_range(0, 255);
    else code = LETTERS[BTN_W*$urandom_range(0, NUM_LETTERS-1) +: BTN_W];
    // Turn the remote and joystick back on soon so most samples get through.
    if (!mixer.enables.remote_enabled && $urandom_range(0, 1))
      send_msg(CMD_BUTTON, jx, jy, BTN_E, allowed);
    else if (!mixer.enables.joystick_enabled && $urandom_range(0, 1))
      send_msg(CMD_BUTTON, jx, jy, BTN_LG, allowed);
    else if ($urandom_range(0, 99) < 55)
      send_msg(CMD_JOYSTICK, jx, jy, code, allowed);
    else
      send_msg(CMD_BUTTON, jx, jy, code, allowed);
  endtask

  initial begin
    mixer = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages at the reset configuration.
    send_msg(CMD_JOYSTICK, 127, 127, 0, 1'b1);
    send_msg(CMD_JOYSTICK, -128, -128, 0, 1'b1);
    send_msg(CMD_JOYSTICK, 127, -128, 0, 1'b1);
    send_msg(CMD_JOYSTICK, -128, 127, 0, 1'b1);
    send_msg(CMD_JOYSTICK, 4, -4, 0, 1'b1);
    send_msg(CMD_JOYSTICK, 0, 40, 0, 1'b1);
    send_msg(CMD_JOYSTICK, 40, 0, 0, 1'b1);
    send_msg(CMD_JOYSTICK, 127, 127, 0, 1'b0);
    send_msg(CMD_BUTTON, 0, 0, BTN_U, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_W_, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_L, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_R, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_S, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_U, 1'b0);
    send_msg(CMD_BUTTON, 0, 0, BTN_LA, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_LF, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_F, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_LE, 1'b1);
    send_msg(CMD_JOYSTICK, 127, 0, 0, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_B, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_E, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_LG, 1'b1);
    send_msg(CMD_JOYSTICK, 0, 127, 0, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_LG, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_CODE_HIGH, 1'b1);
    send_msg(CMD_BUTTON, 0, 0, BTN_CODE_LOW, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      in_tvalid <= 1'b0;
      wait_idle();
      configure(phase);
      calm = (phase == 3);
      repeat (PHASE_ITEMS) send_random();
    end
    in_tvalid <= 1'b0;
    wait_idle();
    repeat (6) @(posedge clk);

    if (mixer.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
